FILE: hw/rtl/csr_eps_pkg.sv
// ----------------------------------------------------------------------------
// csr_eps_pkg
// Shared types, constants and helpers of the CSR entry position search block.
// ----------------------------------------------------------------------------
package csr_eps_pkg;

  localparam int unsigned MaxDim     = 256;
  localparam int unsigned MaxEntries = 4096;

  localparam int unsigned RsDepth = MaxDim + 1;            // row start entries
  localparam int unsigned RsAw    = $clog2(RsDepth);       // row start address
  localparam int unsigned PosW    = $clog2(MaxEntries);    // entry position
  localparam int unsigned PtrW    = $clog2(MaxEntries + 1); // pointer, holds count
  localparam int unsigned ColW    = 8;
  localparam int unsigned RowW    = 8;
  localparam int unsigned DimW    = 9;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned WAddrW  = 12;

  typedef enum logic [ModeW-1:0] {
    MODE_EXACT  = 3'd0,
    MODE_RIGHT  = 3'd1,
    MODE_DOWN   = 3'd2,
    MODE_UP     = 3'd3,
    MODE_WR_ROW = 3'd4,
    MODE_WR_COL = 3'd5
  } mode_e;

  typedef enum logic {
    CFG_DIMENSION   = 1'b0,
    CFG_ENTRY_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RS_HI,
    ST_RS_LAST,
    ST_SCAN,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch input beat
    logic decode;   // table writes, read start of row
    logic rs_hi;    // capture first pointer, read next
    logic rs_last;  // capture second pointer, set up scan
    logic scan;     // walk column table
    logic load;     // move result to output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_search;
    logic range_err;
    logic scan_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [PtrW-1:0] sat_ptr(logic [PtrW-1:0] v);
    return (v > PtrW'(MaxEntries)) ? PtrW'(MaxEntries) : v;
  endfunction

endpackage

FILE: hw/rtl/csr_eps_ctrl.sv
// ----------------------------------------------------------------------------
// csr_eps_ctrl
// Sequencer: decode, row pointer fetch, column scan, result hand-off.
// ----------------------------------------------------------------------------
module csr_eps_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  csr_eps_pkg::dp_status_t st_i,
  output csr_eps_pkg::ctrl_cmd_t  cmd_o
);
  import csr_eps_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!st_i.is_search || st_i.range_err) state_d = ST_DONE;
        else                                   state_d = ST_RS_HI;
      end
      ST_RS_HI:   state_d = ST_RS_LAST;
      ST_RS_LAST: state_d = ST_SCAN;
      ST_SCAN: begin
        if (st_i.scan_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DECODE:  cmd_o.decode  = 1'b1;
      ST_RS_HI:   cmd_o.rs_hi   = 1'b1;
      ST_RS_LAST: cmd_o.rs_last = 1'b1;
      ST_SCAN:    cmd_o.scan    = 1'b1;
      ST_DONE:    cmd_o.load    = st_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/csr_eps_dp.sv
// ----------------------------------------------------------------------------
// csr_eps_dp
// Datapath: config registers, row start and column stores, scan pointer,
// output register.
// ----------------------------------------------------------------------------
module csr_eps_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [csr_eps_pkg::PtrW-1:0]       cfg_data_i,
  // input beat fields
  input  logic [csr_eps_pkg::ModeW-1:0]      mode_i,
  input  logic [csr_eps_pkg::RowW-1:0]       row_i,
  input  logic [csr_eps_pkg::ColW-1:0]       col_i,
  input  logic [csr_eps_pkg::WAddrW-1:0]     waddr_i,
  input  logic [csr_eps_pkg::PtrW-1:0]       wdata_i,
  // control
  input  csr_eps_pkg::ctrl_cmd_t             cmd_i,
  output csr_eps_pkg::dp_status_t            st_o,
  // result
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               out_found_o,
  output logic [csr_eps_pkg::PosW-1:0]       out_pos_o,
  output logic                               out_err_o
);
  import csr_eps_pkg::*;

  // config
  logic [DimW-1:0] dim_q;
  logic [PtrW-1:0] ecnt_q;

  // latched beat
  logic [ModeW-1:0]  mode_q;
  logic [RowW-1:0]   row_q;
  logic [ColW-1:0]   col_q;
  logic [WAddrW-1:0] waddr_q;
  logic [PtrW-1:0]   wdata_q;

  // search state
  logic            err_q, found_q;
  logic [PosW-1:0] pos_q;
  logic [PtrW-1:0] lo_q, hi_q, idx_q;
  logic            rd_vld_q;
  logic [PosW-1:0] rd_idx_q;

  // stores
  logic [PtrW-1:0] rs_mem [RsDepth];
  logic [ColW-1:0] col_mem [MaxEntries];
  logic [PtrW-1:0] rs_rdata_q;
  logic [ColW-1:0] col_rdata_q;

  // output register
  logic            out_vld_q, out_found_q, out_err_q;
  logic [PosW-1:0] out_pos_q;

  logic            fwd, in_range, hit_match, hit, range_err, is_search;
  logic [PtrW-1:0] idx_dec;
  logic [PosW-1:0] col_raddr;
  logic [RsAw-1:0] rs_raddr;
  logic            rs_we, rs_re, col_we, col_re, out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= DimW'(MaxDim);
      ecnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DIMENSION:   dim_q  <= cfg_data_i[DimW-1:0];
        CFG_ENTRY_COUNT: ecnt_q <= cfg_data_i;
        default: begin
          dim_q <= dim_q;
        end
      endcase
    end
  end

  // decode
  assign is_search = (mode_q == MODE_EXACT) || (mode_q == MODE_RIGHT) ||
                     (mode_q == MODE_DOWN)  || (mode_q == MODE_UP);
  assign range_err = ((mode_q == MODE_EXACT) || (mode_q == MODE_RIGHT)) &&
                     ((DimW'(row_q) >= dim_q) || (DimW'(col_q) >= dim_q));

  // scan
  assign fwd       = (mode_q != MODE_UP);
  assign idx_dec   = idx_q - PtrW'(1);
  assign in_range  = fwd ? (idx_q < hi_q) : (idx_q != '0);
  assign hit_match = (mode_q == MODE_RIGHT) ? (col_rdata_q > col_q)
                                            : (col_rdata_q == col_q);
  assign hit       = rd_vld_q && hit_match;
  assign col_raddr = fwd ? idx_q[PosW-1:0] : idx_dec[PosW-1:0];

  assign rs_raddr = cmd_i.rs_hi ? (RsAw'(row_q) + RsAw'(1)) : RsAw'(row_q);
  assign rs_re    = cmd_i.decode || cmd_i.rs_hi;
  assign rs_we    = cmd_i.decode && (mode_q == MODE_WR_ROW) &&
                    (waddr_q <= WAddrW'(MaxDim));
  assign col_we   = cmd_i.decode && (mode_q == MODE_WR_COL);
  assign col_re   = cmd_i.scan && !hit && in_range;

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[waddr_q[RsAw-1:0]] <= wdata_q;
    if (rs_re) rs_rdata_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[waddr_q[PosW-1:0]] <= wdata_q[ColW-1:0];
    if (col_re) col_rdata_q <= col_mem[col_raddr];
  end

  // payload latches
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= mode_i;
      row_q   <= row_i;
      col_q   <= col_i;
      waddr_q <= waddr_i;
      wdata_q <= wdata_i;
    end
    if (cmd_i.decode) err_q <= range_err;
    if (cmd_i.rs_hi)  lo_q  <= sat_ptr(rs_rdata_q);
    if (cmd_i.rs_last) begin
      if (mode_q == MODE_DOWN) begin
        idx_q <= sat_ptr(rs_rdata_q);
        hi_q  <= sat_ptr(ecnt_q);
      end else begin
        idx_q <= lo_q;
        hi_q  <= sat_ptr(rs_rdata_q);
      end
    end else if (col_re) begin
      idx_q    <= fwd ? (idx_q + PtrW'(1)) : idx_dec;
      rd_idx_q <= col_raddr;
    end
    if (cmd_i.scan && hit) pos_q <= rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.accept)          found_q <= 1'b0;
      else if (cmd_i.scan && hit) found_q <= 1'b1;
      if (cmd_i.rs_last)         rd_vld_q <= 1'b0;
      else if (cmd_i.scan)       rd_vld_q <= col_re;
    end
  end

  // output register
  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_found_q <= found_q;
      out_pos_q   <= found_q ? pos_q : '0;
      out_err_q   <= err_q;
    end
  end

  assign st_o.is_search = is_search;
  assign st_o.range_err = range_err;
  assign st_o.scan_done = hit || (!rd_vld_q && !in_range);
  assign st_o.out_free  = out_free;

  assign out_valid_o = out_vld_q;
  assign out_found_o = out_found_q;
  assign out_pos_o   = out_pos_q;
  assign out_err_o   = out_err_q;

  // a result is never dropped onto a full, stalled output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_vld_q || out_ready_i))
    else $error("result loaded over an undelivered one");

  // forward column reads stay below the row or entry bound
  a_fwd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && (mode_q != MODE_UP)) |-> (PtrW'(rd_idx_q) < hi_q))
    else $error("column read past scan bound");

  // a range error never reports a hit
  a_err_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_err_q) |-> !out_found_q)
    else $error("range error with found set");

endmodule

FILE: hw/rtl/csr_entry_position_search_core.sv
// ----------------------------------------------------------------------------
// csr_entry_position_search_core
// Position lookup in a compressed-sparse-row index (row starts + columns).
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one item per beat: tuser = mode; tdata = row, col,
//    write_address, write_data. Modes 4/5 load the row start and column
//    tables; modes 0..3 search them. Every beat gives one m_axis beat.
//  - m_axis: tdata = position, tuser = found, range_error.
//  - cfg: index 0 dimension, index 1 entry_count; write only while idle.
// Flow:
//  - Write, unused mode or range error: DECODE, then DONE loads the result
//    register. Search: DECODE, RS_HI, RS_LAST, SCAN over the walked entries, then DONE; the
//    column scan reads one column table entry per cycle from its single
//    port, so row and column walk length sets the rate.
//  - One item is in work at a time; the next beat is taken while the previous
//    result still waits in the output register.
// Reset: config returns to dimension 256, entry_count 0; tables keep no reset
// value and must be loaded before they are searched.
// Stall: a held result blocks the hand-off of the next one, and no beat is taken until then.
// ----------------------------------------------------------------------------
module csr_entry_position_search_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // [7:0] row, [15:8] col,
                                       // [27:16] write_address,
                                       // [40:28] write_data, [47:41] zero
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] mode
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [11:0] position, [15:12] zero
  output logic [1:0]  m_axis_tuser_o   // [0] found, [1] range_error
);
  import csr_eps_pkg::*;

  ctrl_cmd_t       cmd;
  dp_status_t      st;
  logic            in_ready;
  logic            out_found, out_err;
  logic [PosW-1:0] out_pos;

  // config registers are plain flops; writes always land
  assign cfg_ready_o = 1'b1;

  csr_eps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (in_ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  csr_eps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (s_axis_tuser_i),
    .row_i       (s_axis_tdata_i[7:0]),
    .col_i       (s_axis_tdata_i[15:8]),
    .waddr_i     (s_axis_tdata_i[27:16]),
    .wdata_i     (s_axis_tdata_i[40:28]),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_found_o (out_found),
    .out_pos_o   (out_pos),
    .out_err_o   (out_err)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tdata_o  = {4'b0000, out_pos};
  assign m_axis_tuser_o  = {out_err, out_found};

endmodule

FILE: dv/csr_entry_position_search_checker.sv
// ----------------------------------------------------------------------------
// csr_entry_position_search_checker
// Watches the config, input and result channels of the CSR position search
// core. Keeps its own copy of the row start and column tables, predicts one
// result per input beat and compares each result beat field by field.
// ----------------------------------------------------------------------------
module csr_entry_position_search_checker
  import csr_eps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,   // [7:0] row, [15:8] col, [27:16] write_address,
                                   // [40:28] write_data, [47:41] zero
  input  logic [2:0]  s_tuser_i,   // [2:0] mode
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // [11:0] position, [15:12] zero
  input  logic [1:0]  m_tuser_i,   // [0] found, [1] range_error
  output int          pending_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NoHit = -1;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
    logic            range_error;
  } lookup_res_t;

  logic [PtrW-1:0] row_start_mem [RsDepth];
  logic [ColW-1:0] col_idx_mem   [MaxEntries];
  logic [DimW-1:0] dimension_q;
  logic [PtrW-1:0] entry_count_q;
  lookup_res_t     awaited_results [$];
  int              err_cnt = 0;

  function automatic int clip_ptr(int v);
    return (v > int'(MaxEntries)) ? int'(MaxEntries) : v;
  endfunction

  function automatic int row_start(int r);
    if (r > int'(MaxDim)) return 0;
    return clip_ptr(int'(row_start_mem[RsAw'(r)]));
  endfunction

  function automatic int scan_row(int r, int c, bit greater);
    int lo;
    int hi;
    lo = row_start(r);
    hi = row_start(r + 1);
    for (int i = lo; i < hi; i++) begin
      if (greater ? (int'(col_idx_mem[PosW'(i)]) > c)
                  : (int'(col_idx_mem[PosW'(i)]) == c)) return i;
    end
    return NoHit;
  endfunction

  function automatic int scan_down(int r, int c);
    int last;
    last = clip_ptr(int'(entry_count_q));
    for (int i = row_start(r + 1); i < last; i++) begin
      if (int'(col_idx_mem[PosW'(i)]) == c) return i;
    end
    return NoHit;
  endfunction

  function automatic int scan_up(int r, int c);
    int i;
    i = row_start(r);
    while (i > 0) begin
      i--;
      if (int'(col_idx_mem[PosW'(i)]) == c) return i;
    end
    return NoHit;
  endfunction

  // table writes update the local copy; searches read it
  function automatic lookup_res_t predict_lookup(logic [ModeW-1:0] mode, logic [47:0] data);
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [WAddrW-1:0] waddr;
    logic [PtrW-1:0]   wdata;
    int                hit;
    lookup_res_t       res;
    row   = data[7:0];
    col   = data[15:8];
    waddr = data[27:16];
    wdata = data[40:28];
    hit   = NoHit;
    res   = '0;
    case (mode)
      MODE_EXACT, MODE_RIGHT: begin
        if (row >= dimension_q || col >= dimension_q) res.range_error = 1'b1;
        else hit = scan_row(int'(row), int'(col), mode == MODE_RIGHT);
      end
      MODE_DOWN:   hit = scan_down(int'(row), int'(col));
      MODE_UP:     hit = scan_up(int'(row), int'(col));
      MODE_WR_ROW: if (waddr <= WAddrW'(MaxDim)) row_start_mem[waddr[RsAw-1:0]] = wdata;
      // a 12-bit address always lies inside the column table
      MODE_WR_COL: col_idx_mem[waddr] = wdata[ColW-1:0];
      default: ;
    endcase
    if (hit != NoHit) begin
      res.found    = 1'b1;
      res.position = hit[PosW-1:0];
    end
    return res;
  endfunction

  task automatic compare_field(string name, int want, int seen);
    if (want != seen) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    lookup_res_t want;
    lookup_res_t seen;
    if (!rst_ni) begin
      dimension_q   = DimW'(MaxDim);
      entry_count_q = '0;
      awaited_results.delete();
    end else begin
      // result first: its item was taken on an earlier edge
      if (m_tvalid_i && m_tready_i) begin
        seen.found       = m_tuser_i[0];
        seen.position    = m_tdata_i[PosW-1:0];
        seen.range_error = m_tuser_i[1];
        if (awaited_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat with nothing pending, expected none, actual position %0d",
                   $time, seen.position);
        end else begin
          want = awaited_results.pop_front();
          compare_field("found", int'(want.found), int'(seen.found));
          compare_field("position", int'(want.position), int'(seen.position));
          compare_field("range_error", int'(want.range_error), int'(seen.range_error));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DIMENSION:   dimension_q   = cfg_data_i[DimW-1:0];
          CFG_ENTRY_COUNT: entry_count_q = cfg_data_i[PtrW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        awaited_results.push_back(predict_lookup(s_tuser_i, s_tdata_i));
    end
    pending_o <= awaited_results.size();
    errors_o  <= err_cnt;
  end

endmodule

FILE: dv/csr_entry_position_search_core_tb.sv
// ----------------------------------------------------------------------------
// csr_entry_position_search_core_tb
// Loads a CSR index through the input stream, then runs directed and random
// searches and table writes under several geometry settings, with random
// gaps on both streams. A separate checker predicts every result.
// ----------------------------------------------------------------------------
module csr_entry_position_search_core_tb
  import csr_eps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdlePct       = 23;
  localparam int unsigned RandomItems   = 360;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned CalmPhase     = 3;    // no gaps on either side here
  localparam int unsigned TailCycles    = 40;
  // longest correct search walks the loaded column entries
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxRowLen     = 2;    // at most this many entries per row in the loaded index
  localparam int unsigned SmallCols     = 15;   // most columns live in 0..SmallCols
  // column entries loaded; every pointer and, but for the zero-dimension check, the entry count stay within it
  localparam int unsigned LoadCols      = 256;

  // modes that the block ignores
  localparam logic [ModeW-1:0] ModeSpareLo = 3'd6;
  localparam logic [ModeW-1:0] ModeSpareHi = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [12:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        calm;
  int          pending;
  int          errors;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  csr_entry_position_search_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  csr_entry_position_search_checker u_lookup_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // Result side backpressure: ready drops in about IdlePct of cycles,
  // except in the calm phase.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // Watchdog: any accepted beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // One input beat. Random gap first (valid low), then valid is held until
  // the handshake edge. Valid is never dropped and raised in the same step.
  task automatic send_beat(logic [ModeW-1:0] mode, logic [RowW-1:0] row,
                           logic [ColW-1:0] col, logic [WAddrW-1:0] waddr,
                           logic [PtrW-1:0] wdata);
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'b0, wdata, waddr, col, row};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every result has been taken; the block is
  // then idle, since each beat yields exactly one result.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Both registers in back-to-back beats; valid stays high in between.
  task automatic set_geometry(int unsigned dim, int unsigned count);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DIMENSION;
    cfg_data  <= 13'(dim);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_data  <= 13'(count);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Column values cluster in a small range so scans stay short and hit,
  // with a tail over the whole data range (bit 12 included).
  function automatic logic [PtrW-1:0] col_value();
    return ($urandom_range(99) < 80) ? PtrW'($urandom_range(SmallCols))
                                     : PtrW'($urandom_range(MaxEntries));
  endfunction

  // Well-formed index: monotonic row starts with short rows, capped at the
  // loaded part, then every loaded column entry written, so that no search
  // can reach an unloaded entry.
  task automatic load_tables();
    int unsigned ptr;
    ptr = 0;
    for (int r = 0; r <= int'(MaxDim); r++) begin
      send_beat(MODE_WR_ROW, RowW'($urandom_range(255)), ColW'($urandom_range(255)),
                WAddrW'(r), PtrW'(ptr));
      ptr += $urandom_range(MaxRowLen);
      if (ptr > LoadCols) ptr = LoadCols;
    end
    for (int a = 0; a < int'(LoadCols); a++)
      send_beat(MODE_WR_COL, RowW'($urandom_range(255)), ColW'($urandom_range(255)),
                WAddrW'(a), col_value());
  endtask

  // Mostly searches with columns from the populated range; some table
  // writes that reshape rows (long, empty or inverted) and columns.
  task automatic send_random_item();
    int unsigned       pick;
    logic [ModeW-1:0]  mode;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [WAddrW-1:0] waddr;
    logic [PtrW-1:0]   wdata;
    pick  = $urandom_range(99);
    row   = RowW'($urandom_range(255));
    col   = ($urandom_range(99) < 85) ? ColW'($urandom_range(SmallCols))
                                      : ColW'($urandom_range(255));
    waddr = WAddrW'($urandom_range(MaxEntries - 1));
    wdata = PtrW'($urandom_range(MaxEntries));
    if (pick < 8) begin
      mode = MODE_WR_ROW;
      if ($urandom_range(9) != 0) waddr = WAddrW'($urandom_range(MaxDim));
      wdata = PtrW'($urandom_range(LoadCols));
    end else if (pick < 16) begin
      mode  = MODE_WR_COL;
      if ($urandom_range(9) != 0) waddr = WAddrW'($urandom_range(LoadCols - 1));
      wdata = col_value();
    end else begin
      mode = ModeW'($urandom_range(int'(MODE_UP)));
    end
    send_beat(mode, row, col, waddr, wdata);
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DIMENSION;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= MODE_EXACT;
    m_tready  <= 1'b0;
    calm      <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_geometry(MaxDim, LoadCols);
    load_tables();

    // --- directed: field extremes, every mode ---
    send_beat(MODE_EXACT, 0, 0, 0, 0);
    send_beat(MODE_EXACT, 255, 255, 0, 0);
    send_beat(MODE_RIGHT, 255, 255, 0, 0);          // nothing greater than 255
    send_beat(MODE_RIGHT, 0, 0, 0, 0);
    send_beat(MODE_DOWN, 255, 0, 0, 0);
    send_beat(MODE_UP, 0, 5, 0, 0);                 // row 0 starts at 0: empty walk
    send_beat(MODE_UP, 255, 255, 0, 0);
    // last pointer at the end of the loaded part: row 255 spans to it
    send_beat(MODE_WR_ROW, 0, 0, MaxDim, LoadCols);
    send_beat(MODE_EXACT, 255, 3, 0, 0);
    // row start writes past the table are dropped, then a write to the last column entry
    send_beat(MODE_WR_ROW, 0, 0, MaxDim + 1, 0);
    send_beat(MODE_WR_ROW, 255, 255, MaxEntries - 1, 0);
    send_beat(MODE_WR_COL, 0, 0, MaxEntries - 1, MaxEntries); // low byte only
    // inverted row range, then an empty one
    send_beat(MODE_WR_ROW, 0, 0, 10, 50);
    send_beat(MODE_WR_ROW, 0, 0, 11, 20);
    send_beat(MODE_EXACT, 10, 0, 0, 0);
    send_beat(MODE_WR_ROW, 0, 0, 11, 50);
    send_beat(MODE_RIGHT, 10, 0, 0, 0);
    // ignored modes
    send_beat(ModeSpareLo, 1, 2, 3, 4);
    send_beat(ModeSpareHi, 255, 255, MaxEntries - 1, MaxEntries);
    drain();

    // smallest dimension: range errors in exact/right, none in down/up;
    // entry count 0 leaves the downward scan empty
    set_geometry(1, 0);
    send_beat(MODE_EXACT, 0, 1, 0, 0);
    send_beat(MODE_RIGHT, 1, 0, 0, 0);
    send_beat(MODE_EXACT, 0, 0, 0, 0);
    send_beat(MODE_DOWN, 200, 7, 0, 0);
    send_beat(MODE_UP, 200, 7, 0, 0);
    drain();

    // zero dimension: every exact/right query is out of range
    set_geometry(0, MaxEntries);
    send_beat(MODE_EXACT, 0, 0, 0, 0);
    send_beat(MODE_RIGHT, 0, 0, 0, 0);

    // --- random phases, each setting a geometry first ---
    for (int p = 0; p < int'(NumPhases); p++) begin
      drain();
      calm <= (p == int'(CalmPhase));
      case (p)
        0, 5:    set_geometry(MaxDim, LoadCols);
        1:       set_geometry(1, 0);
        3:       set_geometry(MaxDim / 2, LoadCols / 2);
        default: set_geometry($urandom_range(MaxDim, 1), $urandom_range(LoadCols));
      endcase
      repeat (RandomItems / NumPhases) send_random_item();
    end

    drain();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/csr_eps_pkg.sv
hw/rtl/csr_eps_ctrl.sv
hw/rtl/csr_eps_dp.sv
hw/rtl/csr_entry_position_search_core.sv
dv/csr_entry_position_search_checker.sv
dv/csr_entry_position_search_core_tb.sv
